// ===== sv/msd_pkg.sv =====
// Shared constants, types and the cosine table builder for the multi-tone synthesizer.
`default_nettype none

package msd_pkg;

   localparam int MAX_TONES     = 32;
   localparam int PHASE_BITS    = 32;
   localparam int COS_ADDR_BITS = 10;

   localparam int ROM_SIZE      = 1 << COS_ADDR_BITS;
   localparam int TONE_IDX_BITS = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
   localparam int ACTIVE_BITS   = $clog2(MAX_TONES + 1);
   localparam int MAX_RUN       = 64;
   localparam int COUNT_BITS    = 7;
   localparam int AMP_BITS      = 16;
   localparam int MAG_BITS      = 15;
   localparam int PROD_BITS     = AMP_BITS + MAG_BITS;
   localparam int SAMPLE_BITS   = 37;
   localparam int STEP_IN_BITS  = 32;

   localparam logic [1:0] OP_CLEAR    = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_GENERATE = 2'd2;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] COS_PEAK    = 64'd32767;
   localparam int          TAYLOR_TERMS = 12;
   localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
   };

   typedef logic [MAG_BITS-1:0] cos_rom_type [ROM_SIZE];

   typedef struct packed {
      logic                     valid;
      logic [TONE_IDX_BITS-1:0] addr;
   } tone_rd_type;

   typedef struct packed {
      logic                     valid;
      logic [TONE_IDX_BITS-1:0] addr;
      logic [PHASE_BITS-1:0]    step;
      logic [PHASE_BITS-1:0]    offset;
      logic [AMP_BITS-1:0]      amp;
   } tone_wr_type;

   typedef struct packed {
      logic                  valid;
      logic [PHASE_BITS-1:0] phase;
      logic [AMP_BITS-1:0]   amp;
   } tone_data_type;

   typedef struct packed {
      logic                valid;
      logic                negate;
      logic [MAG_BITS-1:0] mag;
      logic [AMP_BITS-1:0] amp;
   } cos_data_type;

   typedef struct packed {
      logic                          pending;
      logic signed [SAMPLE_BITS-1:0] sum;
   } mac_out_type;

   // Quarter-wave cosine table evaluated at elaboration with a Q30 Taylor series.
   function automatic cos_rom_type build_cos_rom();
      cos_rom_type        rom;
      logic [63:0]        theta;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] acc;
      for (int k = 0; k < ROM_SIZE; k++) begin
         theta = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (COS_ADDR_BITS + 1);
         x2    = (theta * theta) >> 30;
         term  = ONE_Q30;
         acc   = signed'(ONE_Q30);
         for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n % 2) == 1) begin
               acc = acc - signed'(term);
            end else begin
               acc = acc + signed'(term);
            end
         end
         if (acc < 0) begin
            acc = 64'sd0;
         end
         if (acc > signed'(ONE_Q30)) begin
            acc = signed'(ONE_Q30);
         end
         v = (unsigned'(acc) * COS_PEAK + (ONE_Q30 >> 1)) >> 30;
         rom[k] = v[MAG_BITS-1:0];
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

// ===== sv/multi_tone_synthesizer.sv =====
// Top level of the multi-tone synthesizer: command sequencer and result register.
//
// A command is transferred at a rising edge where start is high and busy is low.
// req_operation selects clear, add tone or generate. Clear and add produce no
// result; an add to a full bank of 32 tones is dropped.
// Generate produces one result per sample, up to 64 (larger counts saturate).
// Each result is shown on rsp_sample and rsp_last for one cycle with rsp_strobe
// high, and the receiver must take it then; it cannot stall the block.
// Every sample walks the active tones through one shared multiply-accumulate,
// one tone per cycle, then waits for the four-stage pipeline to empty before
// its result is registered. busy falls in the cycle that shows the last result.
// The tone bank holds accumulator, step, offset and amplitude memories read at
// one address per cycle. Reset empties the bank and returns the block to idle.
`default_nettype none

module multi_tone_synthesizer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_operation,
   input  wire logic [msd_pkg::STEP_IN_BITS-1:0]    req_tone_step,
   input  wire logic [msd_pkg::AMP_BITS-1:0]        req_tone_amplitude,
   input  wire logic [msd_pkg::STEP_IN_BITS-1:0]    req_tone_phase,
   input  wire logic [msd_pkg::COUNT_BITS-1:0]      req_sample_count,
   output logic                                     rsp_strobe,
   output logic signed [msd_pkg::SAMPLE_BITS-1:0]   rsp_sample,
   output logic                                     rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type                            state_ff;
   logic [msd_pkg::ACTIVE_BITS-1:0]      active_ff;
   logic [msd_pkg::TONE_IDX_BITS-1:0]    tone_ff;
   logic [msd_pkg::COUNT_BITS-1:0]       left_ff;
   logic                                 rsp_strobe_ff;
   logic                                 rsp_last_ff;
   logic signed [msd_pkg::SAMPLE_BITS-1:0] rsp_sample_ff;

   logic                           accept;
   logic                           pipe_busy;
   logic                           bank_full;
   logic                           last_tone;
   logic                           mac_clear;
   logic [msd_pkg::COUNT_BITS-1:0] count_sat;

   msd_pkg::tone_wr_type   add_wr;
   msd_pkg::tone_rd_type   rd_req;
   msd_pkg::tone_data_type tone_data;
   msd_pkg::cos_data_type  cos_data;
   msd_pkg::mac_out_type   mac_out;

   always_comb begin
      busy      = (state_ff != ST_IDLE);
      accept    = start && !busy;
      pipe_busy = tone_data.valid || cos_data.valid || mac_out.pending;
      bank_full = (active_ff >= msd_pkg::ACTIVE_BITS'(msd_pkg::MAX_TONES));
      last_tone = (msd_pkg::ACTIVE_BITS'(tone_ff) ==
                   (active_ff - msd_pkg::ACTIVE_BITS'(1)));
      count_sat = (req_sample_count > msd_pkg::COUNT_BITS'(msd_pkg::MAX_RUN)) ?
                  msd_pkg::COUNT_BITS'(msd_pkg::MAX_RUN) : req_sample_count;

      add_wr.valid  = accept && (req_operation == msd_pkg::OP_ADD) && !bank_full;
      add_wr.addr   = active_ff[msd_pkg::TONE_IDX_BITS-1:0];
      add_wr.step   = req_tone_step[msd_pkg::STEP_IN_BITS-1 -: msd_pkg::PHASE_BITS];
      add_wr.offset = req_tone_phase[msd_pkg::STEP_IN_BITS-1 -: msd_pkg::PHASE_BITS];
      add_wr.amp    = req_tone_amplitude;

      rd_req.valid = (state_ff == ST_ISSUE) && (active_ff != '0);
      rd_req.addr  = tone_ff;

      mac_clear = (accept && (req_operation == msd_pkg::OP_GENERATE)) ||
                  ((state_ff == ST_DRAIN) && !pipe_busy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         tone_ff       <= '0;
         left_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_operation)
                     msd_pkg::OP_CLEAR: begin
                        active_ff <= '0;
                     end
                     msd_pkg::OP_ADD: begin
                        if (!bank_full) begin
                           active_ff <= active_ff + msd_pkg::ACTIVE_BITS'(1);
                        end
                     end
                     msd_pkg::OP_GENERATE: begin
                        if (count_sat != '0) begin
                           left_ff  <= count_sat;
                           tone_ff  <= '0;
                           state_ff <= ST_ISSUE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_ISSUE: begin
               if ((active_ff == '0) || last_tone) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  tone_ff <= tone_ff + msd_pkg::TONE_IDX_BITS'(1);
               end
            end
            ST_DRAIN: begin
               if (!pipe_busy) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_sample_ff <= mac_out.sum;
                  rsp_last_ff   <= (left_ff == msd_pkg::COUNT_BITS'(1));
                  if (left_ff == msd_pkg::COUNT_BITS'(1)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     left_ff  <= left_ff - msd_pkg::COUNT_BITS'(1);
                     tone_ff  <= '0;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

   msd_tone_bank u_tone_bank (
      .clock     (clock),
      .reset     (reset),
      .add_wr    (add_wr),
      .rd_req    (rd_req),
      .tone_data (tone_data)
   );

   msd_cos_lookup u_cos_lookup (
      .clock     (clock),
      .reset     (reset),
      .tone_data (tone_data),
      .cos_data  (cos_data)
   );

   msd_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .clear    (mac_clear),
      .cos_data (cos_data),
      .mac_out  (mac_out)
   );

`ifndef SYNTHESIS
   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff <= msd_pkg::ACTIVE_BITS'(msd_pkg::MAX_TONES))
      else $error("tone count exceeds bank size");

   a_strobe_from_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_DRAIN) && !$past(pipe_busy))
      else $error("result issued before the pipeline emptied");

   a_add_counts: assert property (@(posedge clock) disable iff (reset)
      add_wr.valid |=> active_ff == $past(active_ff) + msd_pkg::ACTIVE_BITS'(1))
      else $error("accepted add did not grow the bank");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_busy)
      else $error("pipeline active while idle");
`endif

endmodule

`default_nettype wire

// ===== sv/msd_tone_bank.sv =====
// Tone storage: phase accumulators, steps, offsets and amplitudes with accumulator update.
`default_nettype none

module msd_tone_bank (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire msd_pkg::tone_wr_type   add_wr,
   input  wire msd_pkg::tone_rd_type   rd_req,
   output msd_pkg::tone_data_type      tone_data
);

   logic [msd_pkg::PHASE_BITS-1:0] acc_mem  [msd_pkg::MAX_TONES];
   logic [msd_pkg::PHASE_BITS-1:0] step_mem [msd_pkg::MAX_TONES];
   logic [msd_pkg::PHASE_BITS-1:0] ofs_mem  [msd_pkg::MAX_TONES];
   logic [msd_pkg::AMP_BITS-1:0]   amp_mem  [msd_pkg::MAX_TONES];

   logic                              rd_valid_ff;
   logic [msd_pkg::TONE_IDX_BITS-1:0] rd_addr_ff;
   logic [msd_pkg::PHASE_BITS-1:0]    acc_rd_ff;
   logic [msd_pkg::PHASE_BITS-1:0]    step_rd_ff;
   logic [msd_pkg::PHASE_BITS-1:0]    ofs_rd_ff;
   logic [msd_pkg::AMP_BITS-1:0]      amp_rd_ff;

   always_ff @(posedge clock) begin
      if (add_wr.valid) begin
         acc_mem[add_wr.addr]  <= '0;
         step_mem[add_wr.addr] <= add_wr.step;
         ofs_mem[add_wr.addr]  <= add_wr.offset;
         amp_mem[add_wr.addr]  <= add_wr.amp;
      end else if (rd_valid_ff) begin
         acc_mem[rd_addr_ff] <= acc_rd_ff + step_rd_ff;
      end
      rd_addr_ff <= rd_req.addr;
      acc_rd_ff  <= acc_mem[rd_req.addr];
      step_rd_ff <= step_mem[rd_req.addr];
      ofs_rd_ff  <= ofs_mem[rd_req.addr];
      amp_rd_ff  <= amp_mem[rd_req.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_req.valid;
      end
   end

   assign tone_data.valid = rd_valid_ff;
   assign tone_data.phase = acc_rd_ff + ofs_rd_ff;
   assign tone_data.amp   = amp_rd_ff;

endmodule

`default_nettype wire

// ===== sv/msd_cos_lookup.sv =====
// Quarter-wave cosine ROM with quadrant folding of the phase.
`default_nettype none

module msd_cos_lookup (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire msd_pkg::tone_data_type tone_data,
   output msd_pkg::cos_data_type       cos_data
);

   localparam msd_pkg::cos_rom_type COS_ROM = msd_pkg::build_cos_rom();

   logic [1:0]                        quad;
   logic [msd_pkg::COS_ADDR_BITS-1:0] idx;
   logic [msd_pkg::COS_ADDR_BITS-1:0] rom_addr;

   logic                         valid_ff;
   logic                         negate_ff;
   logic [msd_pkg::MAG_BITS-1:0] mag_ff;
   logic [msd_pkg::AMP_BITS-1:0] amp_ff;

   always_comb begin
      quad     = tone_data.phase[msd_pkg::PHASE_BITS-1 -: 2];
      idx      = tone_data.phase[msd_pkg::PHASE_BITS-3 -: msd_pkg::COS_ADDR_BITS];
      rom_addr = quad[0] ? ~idx : idx;
   end

   always_ff @(posedge clock) begin
      mag_ff    <= COS_ROM[rom_addr];
      negate_ff <= quad[1] ^ quad[0];
      amp_ff    <= tone_data.amp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tone_data.valid;
      end
   end

   assign cos_data.valid  = valid_ff;
   assign cos_data.negate = negate_ff;
   assign cos_data.mag    = mag_ff;
   assign cos_data.amp    = amp_ff;

endmodule

`default_nettype wire

// ===== sv/msd_mac.sv =====
// Shared multiply-accumulate unit that sums amplitude times cosine over the tones.
`default_nettype none

module msd_mac (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire msd_pkg::cos_data_type cos_data,
   output msd_pkg::mac_out_type       mac_out
);

   logic                                 prod_valid_ff;
   logic                                 prod_neg_ff;
   logic [msd_pkg::PROD_BITS-1:0]        prod_ff;
   logic signed [msd_pkg::SAMPLE_BITS-1:0] sum_ff;
   logic signed [msd_pkg::SAMPLE_BITS-1:0] prod_ext;

   assign prod_ext = signed'(msd_pkg::SAMPLE_BITS'(prod_ff));

   always_ff @(posedge clock) begin
      prod_ff     <= msd_pkg::PROD_BITS'(cos_data.amp) * msd_pkg::PROD_BITS'(cos_data.mag);
      prod_neg_ff <= cos_data.negate;
      if (clear) begin
         sum_ff <= '0;
      end else if (prod_valid_ff) begin
         sum_ff <= prod_neg_ff ? (sum_ff - prod_ext) : (sum_ff + prod_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= cos_data.valid;
      end
   end

   assign mac_out.pending = prod_valid_ff;
   assign mac_out.sum     = sum_ff;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the multi-tone synthesizer: directed table, then random programs.
`timescale 1ns / 100ps

module testbench;

   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam longint      QUARTER_PI2  = 64'd1686629713;
   localparam longint      UNIT_Q30     = 64'd1 << 30;
   localparam int          DRAIN_CYCLES = 2 * (msd_pkg::MAX_TONES + 5);
   localparam int          PHASE_ITEMS  = 120;
   localparam int          TABLE_ROWS   = 20;
   localparam logic signed [msd_pkg::SAMPLE_BITS-1:0] FULL_SCALE = 37'sd2147385345;

   typedef struct packed {
      logic signed [msd_pkg::SAMPLE_BITS-1:0] sample;
      logic                                   last;
   } sample_entry_type;

   typedef struct packed {
      logic [1:0]                             op;
      logic [msd_pkg::STEP_IN_BITS-1:0]       step;
      logic [msd_pkg::AMP_BITS-1:0]           amp;
      logic [msd_pkg::STEP_IN_BITS-1:0]       phase;
      logic [msd_pkg::COUNT_BITS-1:0]         count;
      logic                                   typed;
      logic signed [msd_pkg::SAMPLE_BITS-1:0] typed_sample;
   } command_row_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   start = 1'b0;
   logic                                   busy;
   logic [1:0]                             req_operation = '0;
   logic [msd_pkg::STEP_IN_BITS-1:0]       req_tone_step = '0;
   logic [msd_pkg::AMP_BITS-1:0]           req_tone_amplitude = '0;
   logic [msd_pkg::STEP_IN_BITS-1:0]       req_tone_phase = '0;
   logic [msd_pkg::COUNT_BITS-1:0]         req_sample_count = '0;
   logic                                   rsp_strobe;
   logic signed [msd_pkg::SAMPLE_BITS-1:0] rsp_sample;
   logic                                   rsp_last;

   int                               quarter_cos [msd_pkg::ROM_SIZE];
   int                               tone_count;
   logic [msd_pkg::PHASE_BITS-1:0]   tone_accum [msd_pkg::MAX_TONES];
   logic [msd_pkg::PHASE_BITS-1:0]   tone_step [msd_pkg::MAX_TONES];
   logic [msd_pkg::PHASE_BITS-1:0]   tone_offset [msd_pkg::MAX_TONES];
   logic [msd_pkg::AMP_BITS-1:0]     tone_amp [msd_pkg::MAX_TONES];
   sample_entry_type                 expected_samples [$];
   int                               mismatches = 0;
   int                               sent_items = 0;
   int                               idle_pct = 0;

   command_row_type directed_table [TABLE_ROWS] = '{
      '{msd_pkg::OP_GENERATE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 7'd3,  1'b1, 37'sd0},
      '{msd_pkg::OP_GENERATE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 7'd0,  1'b0, 37'sd0},
      '{OP_UNUSED,            32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 7'h7F, 1'b0, 37'sd0},
      '{msd_pkg::OP_ADD,      32'h0000_0000, 16'hFFFF, 32'h0000_0000, 7'd0,  1'b0, 37'sd0},
      '{msd_pkg::OP_GENERATE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 7'd2,  1'b1, FULL_SCALE},
      '{msd_pkg::OP_CLEAR,    32'h0000_0000, 16'h0000, 32'h0000_0000, 7'd0,  1'b0, 37'sd0},
      '{msd_pkg::OP_ADD,      32'h0000_0000, 16'hFFFF, 32'h8000_0000, 7'd0,  1'b0, 37'sd0},
      '{msd_pkg::OP_GENERATE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 7'd1,  1'b1, -FULL_SCALE},
      '{msd_pkg::OP_CLEAR,    32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 7'h7F, 1'b0, 37'sd0},
      '{msd_pkg::OP_GENERATE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 7'd1,  1'b1, 37'sd0},
      '{msd_pkg::OP_ADD,      32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 7'h7F, 1'b0, 37'sd0},
      '{msd_pkg::OP_ADD,      32'h4000_0000, 16'h0001, 32'h4000_0000, 7'd0,  1'b0, 37'sd0},
      '{msd_pkg::OP_ADD,      32'h0000_0001, 16'h0000, 32'h7FFF_FFFF, 7'd0,  1'b0, 37'sd0},
      '{msd_pkg::OP_ADD,      32'h8000_0000, 16'h8000, 32'h0000_0001, 7'd0,  1'b0, 37'sd0},
      '{msd_pkg::OP_GENERATE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 7'h7F, 1'b0, 37'sd0},
      '{msd_pkg::OP_GENERATE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 7'd64, 1'b0, 37'sd0},
      '{msd_pkg::OP_GENERATE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 7'd65, 1'b0, 37'sd0},
      '{OP_UNUSED,            32'h1234_5678, 16'h5555, 32'h0000_0000, 7'd5,  1'b0, 37'sd0},
      '{msd_pkg::OP_GENERATE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 7'd1,  1'b0, 37'sd0},
      '{msd_pkg::OP_CLEAR,    32'h0000_0000, 16'h0000, 32'h0000_0000, 7'd0,  1'b0, 37'sd0}
   };

   multi_tone_synthesizer u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_tone_step      (req_tone_step),
      .req_tone_amplitude (req_tone_amplitude),
      .req_tone_phase     (req_tone_phase),
      .req_sample_count   (req_sample_count),
      .rsp_strobe         (rsp_strobe),
      .rsp_sample         (rsp_sample),
      .rsp_last           (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void apply_command(
      input logic [1:0]                             op,
      input logic [msd_pkg::STEP_IN_BITS-1:0]       step,
      input logic [msd_pkg::AMP_BITS-1:0]           amp,
      input logic [msd_pkg::STEP_IN_BITS-1:0]       phase,
      input logic [msd_pkg::COUNT_BITS-1:0]         count,
      input logic                                   typed,
      input logic signed [msd_pkg::SAMPLE_BITS-1:0] typed_sample);
      int                             runs;
      int                             idx;
      longint                         total;
      longint                         cos_val;
      logic [msd_pkg::PHASE_BITS-1:0] ph;
      sample_entry_type               entry;
      case (op)
         msd_pkg::OP_CLEAR: begin
            tone_count = 0;
         end
         msd_pkg::OP_ADD: begin
            if (tone_count < msd_pkg::MAX_TONES) begin
               tone_accum[tone_count]  = '0;
               tone_step[tone_count]   = msd_pkg::PHASE_BITS'(
                  step >> (msd_pkg::STEP_IN_BITS - msd_pkg::PHASE_BITS));
               tone_offset[tone_count] = msd_pkg::PHASE_BITS'(
                  phase >> (msd_pkg::STEP_IN_BITS - msd_pkg::PHASE_BITS));
               tone_amp[tone_count]    = amp;
               tone_count++;
            end
         end
         msd_pkg::OP_GENERATE: begin
            runs = (count > msd_pkg::MAX_RUN) ? msd_pkg::MAX_RUN : int'(count);
            for (int s = 0; s < runs; s++) begin
               total = 0;
               for (int t = 0; t < tone_count; t++) begin
                  ph  = tone_accum[t] + tone_offset[t];
                  idx = int'(ph[msd_pkg::PHASE_BITS-3 -: msd_pkg::COS_ADDR_BITS]);
                  case (ph[msd_pkg::PHASE_BITS-1 -: 2])
                     2'd0: cos_val = quarter_cos[idx];
                     2'd1: cos_val = -quarter_cos[msd_pkg::ROM_SIZE-1-idx];
                     2'd2: cos_val = -quarter_cos[idx];
                     default: cos_val = quarter_cos[msd_pkg::ROM_SIZE-1-idx];
                  endcase
                  total = total + longint'(tone_amp[t]) * cos_val;
                  tone_accum[t] = tone_accum[t] + tone_step[t];
               end
               entry.sample = typed ? typed_sample : total[msd_pkg::SAMPLE_BITS-1:0];
               entry.last   = (s == runs - 1);
               expected_samples.push_back(entry);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [msd_pkg::COUNT_BITS-1:0] pick_count();
      case ($urandom_range(9))
         0: return '0;
         1: return msd_pkg::COUNT_BITS'($urandom_range(127, 60));
         default: return msd_pkg::COUNT_BITS'($urandom_range(12, 1));
      endcase
   endfunction

   task automatic send_command(
      input logic [1:0]                             op,
      input logic [msd_pkg::STEP_IN_BITS-1:0]       step,
      input logic [msd_pkg::AMP_BITS-1:0]           amp,
      input logic [msd_pkg::STEP_IN_BITS-1:0]       phase,
      input logic [msd_pkg::COUNT_BITS-1:0]         count,
      input logic                                   typed,
      input logic signed [msd_pkg::SAMPLE_BITS-1:0] typed_sample);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_operation      <= op;
      req_tone_step      <= step;
      req_tone_amplitude <= amp;
      req_tone_phase     <= phase;
      req_sample_count   <= count;
      do @(posedge clock); while (busy !== 1'b0);
      apply_command(op, step, amp, phase, count, typed, typed_sample);
      if (op != OP_UNUSED) sent_items++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      sample_entry_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_samples.size() == 0) begin
            $error("rsp_sample: expected no transfer, actual %0d", rsp_sample);
            mismatches++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want.sample) begin
               $error("rsp_sample: expected %0d, actual %0d", want.sample, rsp_sample);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %0d, actual %0d", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   initial begin
      longint                           theta;
      longint                           x2;
      longint                           term;
      longint                           acc;
      int                               n_adds;
      logic                             extreme;
      logic [msd_pkg::STEP_IN_BITS-1:0] extreme_phase;
      for (int k = 0; k < msd_pkg::ROM_SIZE; k++) begin
         theta = (QUARTER_PI2 * (2 * k + 1)) >>> (msd_pkg::COS_ADDR_BITS + 1);
         x2    = (theta * theta) >>> 30;
         term  = UNIT_Q30;
         acc   = UNIT_Q30;
         for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >>> 30) / ((2 * n - 1) * (2 * n));
            acc  = (n % 2 == 1) ? acc - term : acc + term;
         end
         if (acc < 0) acc = 0;
         if (acc > UNIT_Q30) acc = UNIT_Q30;
         quarter_cos[k] = int'((acc * 32767 + (UNIT_Q30 >>> 1)) >>> 30);
      end
      tone_count = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_table[r]) begin
         send_command(directed_table[r].op, directed_table[r].step, directed_table[r].amp,
                      directed_table[r].phase, directed_table[r].count,
                      directed_table[r].typed, directed_table[r].typed_sample);
      end
      drain_results();

      for (int p = 0; p < 3; p++) begin
         idle_pct = (p == 0) ? 0 : (p == 1) ? 52 : 15;
         while (sent_items < (p + 1) * PHASE_ITEMS) begin
            if ($urandom_range(4) != 0) begin
               send_command(msd_pkg::OP_CLEAR, $urandom(),
                            msd_pkg::AMP_BITS'($urandom()), $urandom(),
                            pick_count(), 1'b0, '0);
               n_adds        = ($urandom_range(3) == 0) ? $urandom_range(36, 30)
                                                        : $urandom_range(8, 0);
               extreme       = ($urandom_range(6) == 0);
               extreme_phase = $urandom_range(1) ? 32'h0000_0000 : 32'h8000_0000;
               repeat (n_adds) begin
                  if (extreme)
                     send_command(msd_pkg::OP_ADD, '0, '1, extreme_phase, pick_count(),
                                  1'b0, '0);
                  else
                     send_command(msd_pkg::OP_ADD, $urandom(),
                                  msd_pkg::AMP_BITS'($urandom()), $urandom(),
                                  pick_count(), 1'b0, '0);
               end
               repeat ($urandom_range(3, 1)) begin
                  send_command(msd_pkg::OP_GENERATE, $urandom(),
                               msd_pkg::AMP_BITS'($urandom()), $urandom(),
                               pick_count(), 1'b0, '0);
               end
            end else begin
               send_command(2'($urandom_range(3)), $urandom(),
                            msd_pkg::AMP_BITS'($urandom()), $urandom(),
                            msd_pkg::COUNT_BITS'($urandom_range(127)), 1'b0, '0);
            end
         end
         drain_results();
      end

      if (mismatches == 0 && expected_samples.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/msd_pkg.sv
sv/msd_tone_bank.sv
sv/msd_cos_lookup.sv
sv/msd_mac.sv
sv/multi_tone_synthesizer.sv
bench/testbench.sv
